// ===== sv/ssaa_pkg.sv =====
// Shared types and constants for the supersampling box downsampler.
// Used by the controller, the datapath and the top level; no dependencies.
package ssaa_pkg;

  localparam int MAX_FACTOR    = 8;
  localparam int MAX_OUT_WIDTH = 1024;

  localparam int FACTOR_W = 4;
  localparam int WIDTH_W  = 11;
  localparam int COL_W    = $clog2(MAX_OUT_WIDTH);
  localparam int SUB_W    = $clog2(MAX_FACTOR);
  localparam int CHAN_W   = 8;
  localparam int SUM_W    = 14;
  localparam int N2_W     = 8;
  localparam int RAM_W    = 7 * SUM_W;
  localparam int DIV_NUM_W = 24;
  localparam int STEP_W   = 5;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam logic [STEP_W-1:0] DIV_LAST_STEP = STEP_W'(DIV_NUM_W - 1);
  localparam logic [9:0]        HOLD_SCALE    = 10'd1000;
  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE  = 8'd255;

  // Register select is the word address bit.
  localparam logic REG_FACTOR    = 1'b0;
  localparam logic REG_OUT_WIDTH = 1'b1;

  localparam logic [1:0] CH_ALPHA = 2'd3;

  typedef struct packed {
    logic       take;
    logic       prod;
    logic       sum;
    logic       classify;
    logic       div_load;
    logic       div_step;
    logic       div_store;
    logic       out_load;
    logic [1:0] chan;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } ctrl_status_t;

endpackage

// ===== sv/ssaa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ssaa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/ssaa_ctrl.sv =====
// Sequencer for the downsampler: accept, accumulate, classify, divide, emit.
// Depends on ssaa_pkg.
module ssaa_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ssaa_pkg::ctrl_status_t status,
  output ssaa_pkg::ctrl_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_PROD, S_SUM, S_CLASS, S_DLOAD, S_DRUN, S_DNEXT, S_OUT
  } state_t;

  state_t                    state, state_next;
  logic [1:0]                chan, chan_next;
  logic [ssaa_pkg::STEP_W-1:0] step, step_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    chan_next  = chan;
    step_next  = step;
    cmd        = '0;
    cmd.chan   = chan;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_PROD;
        end
      end
      S_PROD: begin
        cmd.prod   = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = status.last ? S_CLASS : S_IDLE;
      end
      S_CLASS: begin
        cmd.classify = 1'b1;
        chan_next    = 2'd0;
        state_next   = S_DLOAD;
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        step_next    = '0;
        state_next   = S_DRUN;
      end
      S_DRUN: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == ssaa_pkg::DIV_LAST_STEP) begin
          state_next = S_DNEXT;
        end
      end
      S_DNEXT: begin
        cmd.div_store = 1'b1;
        if (chan == ssaa_pkg::CH_ALPHA) begin
          state_next = S_OUT;
        end else begin
          chan_next  = chan + 1'b1;
          state_next = S_DLOAD;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      chan  <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      chan  <= chan_next;
      step  <= step_next;
    end
  end

endmodule

// ===== sv/ssaa_dp.sv =====
// Datapath: position counters, line-store accumulation, shared restoring divider
// and output register. Depends on ssaa_pkg and ssaa_ram.
module ssaa_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  ssaa_pkg::ctrl_cmd_t               cmd,
  output ssaa_pkg::ctrl_status_t            status,
  input  logic [ssaa_pkg::FACTOR_W-1:0]     factor,
  input  logic [ssaa_pkg::WIDTH_W-1:0]      out_width,
  input  logic                              frame_start,
  input  logic [ssaa_pkg::CHAN_W-1:0]       in_red,
  input  logic [ssaa_pkg::CHAN_W-1:0]       in_green,
  input  logic [ssaa_pkg::CHAN_W-1:0]       in_blue,
  input  logic [ssaa_pkg::CHAN_W-1:0]       in_alpha,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ssaa_pkg::CHAN_W-1:0]       out_red,
  output logic [ssaa_pkg::CHAN_W-1:0]       out_green,
  output logic [ssaa_pkg::CHAN_W-1:0]       out_blue,
  output logic [ssaa_pkg::CHAN_W-1:0]       out_alpha,
  output logic [ssaa_pkg::COL_W-1:0]        out_column
);

  localparam int SW = ssaa_pkg::SUM_W;
  localparam int CW = ssaa_pkg::CHAN_W;
  localparam int NW = ssaa_pkg::DIV_NUM_W;

  // position counters
  logic [ssaa_pkg::SUB_W-1:0] sc, sr, sc_now, sr_now, sc_f, sr_f;
  logic [ssaa_pkg::COL_W-1:0] col, col_now, col_f;
  logic [ssaa_pkg::FACTOR_W-1:0] n;
  logic [ssaa_pkg::WIDTH_W-1:0]  w;
  logic [ssaa_pkg::FACTOR_W-1:0] sc_inc, sr_inc;
  logic [ssaa_pkg::WIDTH_W-1:0]  col_inc;
  logic [ssaa_pkg::N2_W-1:0]     n2;
  logic first_now, last_now;

  // latched sample
  logic [CW-1:0]              smp [4];
  logic [ssaa_pkg::COL_W-1:0] col_r;
  logic                       first_r, last_r;
  logic [CW-1:0]              term [3];

  // sums
  logic [ssaa_pkg::RAM_W-1:0] ram_rdata, ram_wdata;
  logic [ssaa_pkg::COL_W-1:0] ram_raddr;
  logic [SW-1:0]              plain [4];
  logic [SW-1:0]              prem [3];
  logic [SW-1:0]              plain_new [4];
  logic [SW-1:0]              prem_new [3];

  // classification and division
  logic          opaque_r, zero_r, held_r;
  logic [NW-1:0] num;
  logic [SW-1:0] rem, den;
  logic [SW:0]   rem_sh;
  logic          ge;
  logic [SW-1:0] div_src;
  logic [9:0]    div_scale;
  logic          by_n2;
  logic [CW-1:0] res [4];
  logic [CW-1:0] q_sat;

  assign n = (factor == '0) ? ssaa_pkg::FACTOR_W'(1) :
             (factor > ssaa_pkg::FACTOR_W'(ssaa_pkg::MAX_FACTOR)) ?
               ssaa_pkg::FACTOR_W'(ssaa_pkg::MAX_FACTOR) : factor;
  assign w = (out_width == '0) ? ssaa_pkg::WIDTH_W'(1) :
             (out_width > ssaa_pkg::WIDTH_W'(ssaa_pkg::MAX_OUT_WIDTH)) ?
               ssaa_pkg::WIDTH_W'(ssaa_pkg::MAX_OUT_WIDTH) : out_width;
  assign n2 = ssaa_pkg::N2_W'(n) * ssaa_pkg::N2_W'(n);

  always_comb begin
    sc_f  = frame_start ? '0 : sc;
    col_f = frame_start ? '0 : col;
    sr_f  = frame_start ? '0 : sr;
    // counters left beyond a shrunken limit restart at zero
    sc_now  = ({1'b0, sc_f} >= n)  ? '0 : sc_f;
    col_now = ({1'b0, col_f} >= w) ? '0 : col_f;
    sr_now  = ({1'b0, sr_f} >= n)  ? '0 : sr_f;
    first_now = (sc_now == '0) && (sr_now == '0);
    last_now  = ({1'b0, sc_now} == n - 1'b1) && ({1'b0, sr_now} == n - 1'b1);
    sc_inc  = {1'b0, sc_now} + 1'b1;
    col_inc = {1'b0, col_now} + 1'b1;
    sr_inc  = {1'b0, sr_now} + 1'b1;
  end

  // every counter takes its cleared value on a beat, even when it does not step
  always_ff @(posedge clk) begin
    if (rst) begin
      sc  <= '0;
      col <= '0;
      sr  <= '0;
    end else if (cmd.take) begin
      if (sc_inc >= n) begin
        sc <= '0;
        if (col_inc >= w) begin
          col <= '0;
          sr  <= (sr_inc >= n) ? '0 : sr_inc[ssaa_pkg::SUB_W-1:0];
        end else begin
          col <= col_inc[ssaa_pkg::COL_W-1:0];
          sr  <= sr_now;
        end
      end else begin
        sc  <= sc_inc[ssaa_pkg::SUB_W-1:0];
        col <= col_now;
        sr  <= sr_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      smp[0]  <= in_red;
      smp[1]  <= in_green;
      smp[2]  <= in_blue;
      smp[3]  <= in_alpha;
      col_r   <= col_now;
      first_r <= first_now;
      last_r  <= last_now;
    end
  end

  // premultiplied term floor(c*a/255), divide by 255 as (x + (x>>8) + 1) >> 8
  always_ff @(posedge clk) begin
    logic [2*CW-1:0] prod;
    logic [2*CW:0]   acc;
    if (cmd.prod) begin
      for (int k = 0; k < 3; k++) begin
        prod    = smp[k] * smp[3];
        acc     = {1'b0, prod} + (2*CW+1)'(prod >> CW) + 1'b1;
        term[k] <= acc[2*CW-1:CW];
      end
    end
  end

  assign ram_raddr = cmd.take ? col_now : col_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      plain_new[k] = (first_r ? '0 : ram_rdata[k*SW +: SW]) + SW'(smp[k]);
    end
    for (int k = 0; k < 3; k++) begin
      prem_new[k] = (first_r ? '0 : ram_rdata[(4+k)*SW +: SW]) + SW'(term[k]);
    end
    ram_wdata = {prem_new[2], prem_new[1], prem_new[0],
                 plain_new[3], plain_new[2], plain_new[1], plain_new[0]};
  end

  ssaa_ram #(
    .WIDTH (ssaa_pkg::RAM_W),
    .DEPTH (ssaa_pkg::MAX_OUT_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (cmd.sum),
    .waddr (col_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      plain <= plain_new;
      prem  <= prem_new;
    end
  end

  assign status.last = last_r;

  always_ff @(posedge clk) begin
    if (cmd.classify) begin
      opaque_r <= ({2'b0, plain[3]} == 16'(n2) * 16'(ssaa_pkg::ALPHA_OPAQUE));
      zero_r   <= (plain[3] == '0);
      held_r   <= (NW'(plain[3]) * NW'(ssaa_pkg::HOLD_SCALE)) <
                  (NW'(n2) * NW'(ssaa_pkg::ALPHA_OPAQUE));
    end
  end

  // divider operand select for the channel being worked
  always_comb begin
    by_n2 = (cmd.chan == ssaa_pkg::CH_ALPHA) || opaque_r || held_r;
    if (cmd.chan == ssaa_pkg::CH_ALPHA) begin
      div_src = plain[3];
    end else if (opaque_r) begin
      div_src = plain[cmd.chan];
    end else begin
      div_src = prem[cmd.chan];
    end
    if ((cmd.chan == ssaa_pkg::CH_ALPHA) || opaque_r) begin
      div_scale = 10'd1;
    end else if (held_r) begin
      div_scale = ssaa_pkg::HOLD_SCALE;
    end else begin
      div_scale = 10'(ssaa_pkg::ALPHA_OPAQUE);
    end
    rem_sh = {rem, num[NW-1]};
    ge     = rem_sh >= {1'b0, den};
    q_sat  = (|num[NW-1:CW]) ? ssaa_pkg::ALPHA_OPAQUE : num[CW-1:0];
  end

  always_ff @(posedge clk) begin
    logic [SW:0] diff;
    diff = rem_sh - {1'b0, den};
    if (cmd.div_load) begin
      num <= NW'(div_src) * NW'(div_scale);
      den <= by_n2 ? SW'(n2) : plain[3];
      rem <= '0;
    end else if (cmd.div_step) begin
      rem <= ge ? diff[SW-1:0] : rem_sh[SW-1:0];
      num <= {num[NW-2:0], ge};
    end
    if (cmd.div_store) begin
      if (zero_r) begin
        res[cmd.chan] <= '0;
      end else if (opaque_r && (cmd.chan == ssaa_pkg::CH_ALPHA)) begin
        res[cmd.chan] <= ssaa_pkg::ALPHA_OPAQUE;
      end else begin
        res[cmd.chan] <= q_sat;
      end
    end
  end

  // output register
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_red    <= res[0];
      out_green  <= res[1];
      out_blue   <= res[2];
      out_alpha  <= res[3];
      out_column <= col_r;
    end
  end

endmodule

// ===== sv/ssaa_box_downsample_alpha.sv =====
// Top level of the supersampling box downsampler with premultiplied alpha.
// Depends on ssaa_pkg, ssaa_ctrl, ssaa_dp (which holds ssaa_ram).
//
// Usage:
//   Input channel (in_valid/in_stall) takes one RGBA supersample per beat in
//   raster order; frame_start on a beat clears the position counters first.
//   Output channel (out_valid/out_stall) gives one averaged pixel and its
//   column once the bottom-right sample of an N x N block is taken.
//   Config over the APB port: factor at 0x0, out_width at 0x4; write only
//   while the block is idle.
// Timing:
//   A sample that does not close a block goes through accept, product and
//   line-store read-modify-write, with in_stall high after accept. A closing
//   sample then has classify and, per channel, divider load, divide and store:
//   the four output channels share one restoring divider that retires one
//   quotient bit per cycle over 24 bits. The result then reaches out_valid.
// Reset: counters clear, output is empty, factor = 1, out_width = 1024.
//   Line-store contents are not cleared; the first sample of each block
//   overwrites its column entry.
// Stall: a held result stays on the outputs; the block keeps taking samples
//   and only waits if the next result is ready before the held one is taken.
module ssaa_box_downsample_alpha (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ssaa_pkg::ADDR_W-1:0]    paddr,
  input  logic [ssaa_pkg::DATA_W-1:0]    pwdata,
  output logic [ssaa_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           frame_start,
  input  logic [ssaa_pkg::CHAN_W-1:0]    in_red,
  input  logic [ssaa_pkg::CHAN_W-1:0]    in_green,
  input  logic [ssaa_pkg::CHAN_W-1:0]    in_blue,
  input  logic [ssaa_pkg::CHAN_W-1:0]    in_alpha,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ssaa_pkg::CHAN_W-1:0]    out_red,
  output logic [ssaa_pkg::CHAN_W-1:0]    out_green,
  output logic [ssaa_pkg::CHAN_W-1:0]    out_blue,
  output logic [ssaa_pkg::CHAN_W-1:0]    out_alpha,
  output logic [ssaa_pkg::COL_W-1:0]     out_column
);

  logic [ssaa_pkg::FACTOR_W-1:0] factor;
  logic [ssaa_pkg::WIDTH_W-1:0]  out_width;
  logic                          wr_en;
  ssaa_pkg::ctrl_cmd_t           cmd;
  ssaa_pkg::ctrl_status_t        status;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      factor    <= ssaa_pkg::FACTOR_W'(1);
      out_width <= ssaa_pkg::WIDTH_W'(ssaa_pkg::MAX_OUT_WIDTH);
    end else if (wr_en) begin
      if (paddr[2] == ssaa_pkg::REG_FACTOR) begin
        factor <= pwdata[ssaa_pkg::FACTOR_W-1:0];
      end else begin
        out_width <= pwdata[ssaa_pkg::WIDTH_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == ssaa_pkg::REG_OUT_WIDTH) ?
                  ssaa_pkg::DATA_W'(out_width) : ssaa_pkg::DATA_W'(factor);

  ssaa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ssaa_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .factor      (factor),
    .out_width   (out_width),
    .frame_start (frame_start),
    .in_red      (in_red),
    .in_green    (in_green),
    .in_blue     (in_blue),
    .in_alpha    (in_alpha),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_alpha   (out_alpha),
    .out_column  (out_column)
  );

endmodule

// ===== sv/ssaa_checker.sv =====
// Port-level checks for the downsampler, attached to the top level by bind.
// Depends on ssaa_pkg and ssaa_box_downsample_alpha.
module ssaa_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [ssaa_pkg::CHAN_W-1:0] out_red,
  input logic [ssaa_pkg::COL_W-1:0]  out_column
);

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a beat");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not empty and ready after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_red) && $stable(out_column))
    else $error("stalled result changed");

endmodule

bind ssaa_box_downsample_alpha ssaa_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_red    (out_red),
  .out_column (out_column)
);
